[hw/rtl/bba_pkg.sv]
// Shared constants, types and helper functions of the buddy block allocator.
`timescale 1ns / 1ps

package bba_pkg;

  // Arena geometry.
  localparam int MAX_ARENA_ORDER   = 16;
  localparam int HEADER_BYTES      = 4;
  localparam int MIN_ORDER         = 2;
  localparam int RESET_ARENA_ORDER = 16;

  // Field widths.
  localparam int ORD_W  = 5;
  localparam int OFF_W  = 16;
  localparam int REQ_W  = 16;
  localparam int USED_W = 17;

  // One mask bit for every order from zero up to the largest arena.
  localparam int MASK_W = MAX_ARENA_ORDER + 1;

  // Heap-indexed tree of nodes and the granule table.
  localparam int TREE_AW    = MAX_ARENA_ORDER - MIN_ORDER + 1;
  localparam int TREE_DEPTH = 1 << TREE_AW;
  localparam int GRAN_AW    = MAX_ARENA_ORDER - MIN_ORDER;
  localparam int GRAN_DEPTH = 1 << GRAN_AW;

  // Action codes.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOSPACE = 2'd1,
    STATUS_BADFREE = 2'd2
  } status_t;

  // Tree memory access requests.
  typedef struct packed {
    logic               en;
    logic [TREE_AW-1:0] addr;
    logic [MASK_W-1:0]  data;
  } tree_wr_t;

  typedef struct packed {
    logic               en;
    logic [TREE_AW-1:0] addr;
  } tree_rd_t;

  // Clamp a written arena order into the supported range.
  function automatic logic [ORD_W-1:0] clamp_order(input logic [ORD_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = v;
    if (v < ORD_W'(MIN_ORDER)) r = ORD_W'(MIN_ORDER);
    if (v > ORD_W'(MAX_ARENA_ORDER)) r = ORD_W'(MAX_ARENA_ORDER);
    return r;
  endfunction

  // Order of a request once the header is added and the size rounded up.
  function automatic logic [ORD_W-1:0] need_order(input logic [REQ_W-1:0] req);
    logic [USED_W-1:0] need;
    logic [USED_W-1:0] nm1;
    logic [ORD_W-1:0]  len;
    need = USED_W'(req) + USED_W'(HEADER_BYTES);
    nm1  = need - USED_W'(1);
    len  = '0;
    for (int i = 0; i < USED_W; i++) begin
      if (nm1[i]) len = ORD_W'(i + 1);
    end
    if (need <= USED_W'(1)) len = '0;
    if (len < ORD_W'(MIN_ORDER)) len = ORD_W'(MIN_ORDER);
    return len;
  endfunction

  // Mask with the single bit of one order set.
  function automatic logic [MASK_W-1:0] order_bit(input logic [ORD_W-1:0] ord);
    return MASK_W'(1) << ord;
  endfunction

  // Mask with the bits of orders lo up to, but not including, top set.
  function automatic logic [MASK_W-1:0] order_range(input logic [ORD_W-1:0] lo,
                                                    input logic [ORD_W-1:0] top);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (ORD_W'(i) >= lo) && (ORD_W'(i) < top);
    end
    return m;
  endfunction

endpackage

[hw/rtl/bba_in_if.sv]
// Request channel of the buddy block allocator.
`timescale 1ns / 1ps

interface bba_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [bba_pkg::REQ_W-1:0] request_bytes;
  logic [bba_pkg::OFF_W-1:0] free_offset;

  modport source (output valid, action, request_bytes, free_offset, input ready);
  modport sink   (input valid, action, request_bytes, free_offset, output ready);
endinterface

[hw/rtl/bba_out_if.sv]
// Result channel of the buddy block allocator.
`timescale 1ns / 1ps

interface bba_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [bba_pkg::OFF_W-1:0]  block_offset;
  logic [bba_pkg::ORD_W-1:0]  block_order;
  logic [bba_pkg::USED_W-1:0] used_bytes;

  modport source (output valid, status, block_offset, block_order, used_bytes, input ready);
  modport sink   (input valid, status, block_offset, block_order, used_bytes, output ready);
endinterface

[hw/rtl/bba_cfg_if.sv]
// Configuration write channel of the buddy block allocator.
`timescale 1ns / 1ps

interface bba_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [bba_pkg::ORD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/buddy_block_allocator.sv]
// Buddy block allocator top level: sequencer, tree memory, granule table, result register.
//
//   channel  | direction | beat carries
//   ---------+-----------+----------------------------------------------
//   in_bus   | sink      | action, request_bytes, free_offset
//   out_bus  | source    | status, block_offset, block_order, used_bytes
//   cfg_bus  | sink      | arena order (clamped, rearms the arena)
//
// There is at most one tree memory access a step.
// After reset and after every configuration write a clearing pass sweeps the tree and
// the granule table; no request beat is taken meanwhile.
// Requests are taken only while the sequencer is idle; a waiting result stalls the
// sequencer at its last step until the result beat is taken.
`timescale 1ns / 1ps

module buddy_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  bba_in_if.sink      in_bus,
  bba_out_if.source   out_bus,
  bba_cfg_if.sink     cfg_bus
);

  typedef enum logic [3:0] {
    S_CLEAR, S_CLROOT, S_IDLE,
    S_ASTART, S_AROOT, S_ADESCR, S_ADESC, S_SPLIT, S_SPLITR,
    S_UP, S_UPW,
    S_FCHK, S_FTBL, S_FMRG, S_FMRGW,
    S_DONE
  } state_t;

  state_t                          state_r;
  logic [bba_pkg::ORD_W-1:0]       arena_r;
  logic [bba_pkg::USED_W-1:0]      used_r;
  logic [bba_pkg::ORD_W-1:0]       ord_r;
  logic [bba_pkg::OFF_W-1:0]       off_r;
  logic [bba_pkg::TREE_AW-1:0]     node_r;
  logic [bba_pkg::ORD_W-1:0]       lvl_r;
  logic [bba_pkg::ORD_W-1:0]       cur_r;
  logic [bba_pkg::TREE_AW-1:0]     up_node_r;
  logic [bba_pkg::MASK_W-1:0]      up_mask_r;
  logic [bba_pkg::TREE_AW-1:0]     clr_r;
  bba_pkg::status_t                res_status_r;
  logic [bba_pkg::OFF_W-1:0]       res_off_r;
  logic [bba_pkg::ORD_W-1:0]       res_ord_r;
  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic [bba_pkg::OFF_W-1:0]       out_off_r;
  logic [bba_pkg::ORD_W-1:0]       out_ord_r;
  logic [bba_pkg::USED_W-1:0]      out_used_r;

  bba_pkg::tree_wr_t               tree_wr;
  bba_pkg::tree_rd_t               tree_rd;
  logic [bba_pkg::MASK_W-1:0]      tree_q;

  logic [bba_pkg::ORD_W-1:0]       tbl_mem [bba_pkg::GRAN_DEPTH];
  logic                            tbl_we;
  logic [bba_pkg::GRAN_AW-1:0]     tbl_waddr;
  logic [bba_pkg::ORD_W-1:0]       tbl_wdata;
  logic                            tbl_re;
  logic [bba_pkg::ORD_W-1:0]       tbl_q;

  logic                            in_fire;
  logic                            cfg_fire;
  logic                            out_free;
  logic                            root_found;
  logic [bba_pkg::ORD_W-1:0]       root_cur;
  logic [bba_pkg::TREE_AW-1:0]     node_left;
  logic [bba_pkg::ORD_W-1:0]       lvl_dn;
  logic                            free_bad;
  logic [bba_pkg::TREE_AW-1:0]     free_node;
  logic [bba_pkg::MASK_W-1:0]      up_merged;

  // Handshakes.
  assign cfg_bus.ready = (state_r == S_IDLE);
  assign in_bus.ready  = (state_r == S_IDLE) && !cfg_bus.valid;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign cfg_fire      = cfg_bus.valid && cfg_bus.ready;
  assign out_free      = !out_valid_r || out_bus.ready;

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.block_offset = out_off_r;
  assign out_bus.block_order  = out_ord_r;
  assign out_bus.used_bytes   = out_used_r;

  // Smallest order at or above the request that has a free block under the root.
  always_comb begin
    root_found = 1'b0;
    root_cur   = '0;
    for (int i = bba_pkg::MASK_W - 1; i >= 0; i--) begin
      if (tree_q[i] && (bba_pkg::ORD_W'(i) >= ord_r)) begin
        root_found = 1'b1;
        root_cur   = bba_pkg::ORD_W'(i);
      end
    end
  end

  // Node arithmetic.
  assign node_left = {node_r[bba_pkg::TREE_AW-2:0], 1'b0};
  assign lvl_dn    = lvl_r - bba_pkg::ORD_W'(1);
  assign free_bad  = ({1'b0, off_r} >= (bba_pkg::USED_W'(1) << arena_r)) ||
                     (off_r[bba_pkg::MIN_ORDER-1:0] != '0);
  assign free_node = (bba_pkg::TREE_AW'(1) << (arena_r - tbl_q)) +
                     bba_pkg::TREE_AW'(off_r >> tbl_q);
  assign up_merged = up_mask_r | tree_q;

  // Tree memory requests: at most one read and one write per step.
  always_comb begin
    tree_wr = '0;
    tree_rd = '0;
    case (state_r)
      S_CLEAR: begin
        tree_wr.en   = 1'b1;
        tree_wr.addr = clr_r;
      end
      S_CLROOT: begin
        tree_wr.en   = 1'b1;
        tree_wr.addr = bba_pkg::TREE_AW'(1);
        tree_wr.data = bba_pkg::order_bit(arena_r);
      end
      S_ASTART: begin
        tree_rd.en   = 1'b1;
        tree_rd.addr = bba_pkg::TREE_AW'(1);
      end
      S_ADESCR: begin
        tree_rd.en   = 1'b1;
        tree_rd.addr = node_left;
      end
      S_SPLIT: begin
        tree_wr.en   = 1'b1;
        tree_wr.addr = node_r;
        tree_wr.data = bba_pkg::order_range(ord_r, lvl_r);
      end
      S_SPLITR: begin
        tree_wr.en   = 1'b1;
        tree_wr.addr = node_left | bba_pkg::TREE_AW'(1);
        tree_wr.data = bba_pkg::order_bit(lvl_dn);
      end
      S_UP: begin
        tree_rd.en   = (up_node_r != bba_pkg::TREE_AW'(1));
        tree_rd.addr = up_node_r ^ bba_pkg::TREE_AW'(1);
      end
      S_UPW: begin
        tree_wr.en   = 1'b1;
        tree_wr.addr = up_node_r >> 1;
        tree_wr.data = up_merged;
      end
      S_FMRG: begin
        if (cur_r == arena_r) begin
          tree_wr.en   = 1'b1;
          tree_wr.addr = node_r;
          tree_wr.data = bba_pkg::order_bit(cur_r);
        end else begin
          tree_rd.en   = 1'b1;
          tree_rd.addr = node_r ^ bba_pkg::TREE_AW'(1);
        end
      end
      S_FMRGW: begin
        tree_wr.en = 1'b1;
        if (tree_q[cur_r]) begin
          tree_wr.addr = node_r ^ bba_pkg::TREE_AW'(1);
          tree_wr.data = '0;
        end else begin
          tree_wr.addr = node_r;
          tree_wr.data = bba_pkg::order_bit(cur_r);
        end
      end
      default: begin
        tree_wr = '0;
        tree_rd = '0;
      end
    endcase
  end

  bba_tree_mem u_tree (
    .clk     (clk),
    .wr      (tree_wr),
    .rd      (tree_rd),
    .rd_data (tree_q)
  );

  // Granule table requests.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = off_r[bba_pkg::OFF_W-1:bba_pkg::MIN_ORDER];
    tbl_wdata = '0;
    tbl_re    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r[bba_pkg::GRAN_AW-1:0];
      end
      S_SPLIT: begin
        tbl_we    = (lvl_r == ord_r);
        tbl_wdata = ord_r;
      end
      S_FCHK: begin
        tbl_re = !free_bad;
      end
      S_FTBL: begin
        tbl_we = (tbl_q != '0);
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // Granule table memory: order of the allocated block starting at each granule.
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_q <= tbl_mem[off_r[bba_pkg::OFF_W-1:bba_pkg::MIN_ORDER]];
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      arena_r     <= bba_pkg::clamp_order(bba_pkg::ORD_W'(bba_pkg::RESET_ARENA_ORDER));
      used_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result step loads the register itself, so the drain is handled elsewhere.
      if (out_valid_r && out_bus.ready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + bba_pkg::TREE_AW'(1);
          if (clr_r == '1) state_r <= S_CLROOT;
        end
        S_CLROOT: begin
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_fire) begin
            arena_r <= bba_pkg::clamp_order(cfg_bus.data);
            used_r  <= '0;
            clr_r   <= '0;
            state_r <= S_CLEAR;
          end else if (in_fire) begin
            ord_r   <= bba_pkg::need_order(in_bus.request_bytes);
            off_r   <= in_bus.free_offset;
            state_r <= (in_bus.action == bba_pkg::ACT_FREE) ? S_FCHK : S_ASTART;
          end
        end
        S_ASTART: begin
          state_r <= S_AROOT;
        end
        S_AROOT: begin
          if ((ord_r > arena_r) || !root_found) begin
            res_status_r <= bba_pkg::STATUS_NOSPACE;
            res_off_r    <= '0;
            res_ord_r    <= '0;
            state_r      <= S_DONE;
          end else begin
            cur_r  <= root_cur;
            node_r <= bba_pkg::TREE_AW'(1);
            off_r  <= '0;
            lvl_r  <= arena_r;
            if (root_cur == arena_r) begin
              up_node_r    <= bba_pkg::TREE_AW'(1);
              up_mask_r    <= bba_pkg::order_range(ord_r, root_cur);
              res_status_r <= bba_pkg::STATUS_OK;
              res_off_r    <= '0;
              res_ord_r    <= ord_r;
              used_r       <= used_r + (bba_pkg::USED_W'(1) << ord_r);
              state_r      <= S_SPLIT;
            end else begin
              state_r <= S_ADESCR;
            end
          end
        end
        S_ADESCR: begin
          state_r <= S_ADESC;
        end
        S_ADESC: begin
          // Go left when the left child holds a free block of the found order.
          lvl_r <= lvl_dn;
          if (tree_q[cur_r]) begin
            node_r <= node_left;
          end else begin
            node_r <= node_left | bba_pkg::TREE_AW'(1);
            off_r  <= off_r + (bba_pkg::OFF_W'(1) << lvl_dn);
          end
          if (lvl_dn == cur_r) begin
            up_node_r    <= tree_q[cur_r] ? node_left : (node_left | bba_pkg::TREE_AW'(1));
            up_mask_r    <= bba_pkg::order_range(ord_r, cur_r);
            res_status_r <= bba_pkg::STATUS_OK;
            res_off_r    <= tree_q[cur_r] ? off_r : (off_r + (bba_pkg::OFF_W'(1) << lvl_dn));
            res_ord_r    <= ord_r;
            used_r       <= used_r + (bba_pkg::USED_W'(1) << ord_r);
            state_r      <= S_SPLIT;
          end else begin
            state_r <= S_ADESCR;
          end
        end
        S_SPLIT: begin
          state_r <= (lvl_r == ord_r) ? S_UP : S_SPLITR;
        end
        S_SPLITR: begin
          // Upper half becomes free; carry on down the lower half.
          node_r  <= node_left;
          lvl_r   <= lvl_dn;
          state_r <= S_SPLIT;
        end
        S_UP: begin
          state_r <= (up_node_r == bba_pkg::TREE_AW'(1)) ? S_DONE : S_UPW;
        end
        S_UPW: begin
          up_node_r <= up_node_r >> 1;
          up_mask_r <= up_merged;
          state_r   <= S_UP;
        end
        S_FCHK: begin
          if (free_bad) begin
            res_status_r <= bba_pkg::STATUS_BADFREE;
            res_off_r    <= '0;
            res_ord_r    <= '0;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_FTBL;
          end
        end
        S_FTBL: begin
          if (tbl_q == '0) begin
            res_status_r <= bba_pkg::STATUS_BADFREE;
            res_off_r    <= '0;
            res_ord_r    <= '0;
            state_r      <= S_DONE;
          end else begin
            used_r       <= used_r - (bba_pkg::USED_W'(1) << tbl_q);
            res_status_r <= bba_pkg::STATUS_OK;
            res_off_r    <= off_r;
            res_ord_r    <= tbl_q;
            cur_r        <= tbl_q;
            node_r       <= free_node;
            state_r      <= S_FMRG;
          end
        end
        S_FMRG: begin
          state_r <= (cur_r == arena_r) ? S_DONE : S_FMRGW;
        end
        S_FMRGW: begin
          // A free buddy is absorbed; otherwise the block settles and the ancestors follow.
          if (tree_q[cur_r]) begin
            node_r  <= node_r >> 1;
            cur_r   <= cur_r + bba_pkg::ORD_W'(1);
            state_r <= S_FMRG;
          end else begin
            up_node_r <= node_r;
            up_mask_r <= bba_pkg::order_bit(cur_r);
            state_r   <= S_UP;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_off_r    <= res_off_r;
            out_ord_r    <= res_ord_r;
            out_used_r   <= used_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The bytes held never exceed the arena.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= (bba_pkg::USED_W'(1) << arena_r))
    else $error("used bytes exceed the arena");

  // A successful block is aligned to its own size.
  a_ok_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == bba_pkg::STATUS_OK)) |->
    ((out_off_r & ~(bba_pkg::OFF_W'('1) << out_ord_r)) == '0))
    else $error("result block is misaligned");

  // A failed step reports neither offset nor order.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != bba_pkg::STATUS_OK)) |->
    ((out_off_r == '0) && (out_ord_r == '0)))
    else $error("failed step carries a block");

  // No request is taken while the memories are being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CLEAR) || (state_r == S_CLROOT)) |-> !in_bus.ready)
    else $error("request taken during clearing pass");

  // The descent always stays above the order it searches for.
  a_desc_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADESC) |-> (lvl_r > cur_r))
    else $error("descent passed the target order");

endmodule

[hw/rtl/bba_tree_mem.sv]
// Tree memory: one order mask per node, one write and one registered read a cycle.
`timescale 1ns / 1ps

module bba_tree_mem (
  input  logic                           clk,
  input  bba_pkg::tree_wr_t              wr,
  input  bba_pkg::tree_rd_t              rd,
  output logic [bba_pkg::MASK_W-1:0]     rd_data
);

  logic [bba_pkg::MASK_W-1:0] mem [bba_pkg::TREE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd.en) rd_data <= mem[rd.addr];
  end

endmodule
